// ----- rtl/encoder_weighted_speed_filter_macros.svh -----
// Assertion macros shared by the speed filter RTL.
`ifndef ENCODER_WEIGHTED_SPEED_FILTER_MACROS_SVH
`define ENCODER_WEIGHTED_SPEED_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every clock edge outside of reset.
`define EWSF_ASSERT_IFF(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define EWSF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define EWSF_ASSERT_IFF(lbl, clk, rstn, prop, msg)
`define EWSF_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/ewsf_pkg.sv -----
// Widths and constants of the encoder weighted speed filter.
package ewsf_pkg;

  localparam int PULSE_W  = 16;
  localparam int SPEED_W  = 13;
  localparam int PERIOD_W = 8;
  localparam int CNT_W    = 9;

  // Divisor of the weighted sum and the limits of the speed word.
  localparam int SPEED_DIVISOR = 150;
  localparam int SPEED_MAX     = 4095;
  localparam int SPEED_MIN_MAG = 4096;

endpackage

// ----- rtl/encoder_weighted_speed_filter.sv -----
// Encoder speed filter: decimated, linearly weighted moving average of pulse counts.
// An accepted sampling word passes via pend_q, sum_vld_q and out_vld_q to out_valid_o.
// One input word per cycle while in_stall_o is low; a result per sample_period+1 words.
// The stall from the output register propagates back through the sum stage to in_stall_o.
// Reset (rst_ni low, asynchronous) clears the period, tick counter, taps and valid flags.
`include "encoder_weighted_speed_filter_macros.svh"

module encoder_weighted_speed_filter
  import ewsf_pkg::*;
#(
  parameter int TAPS = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [PERIOD_W-1:0]       cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [PULSE_W-1:0] pulse_count_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SPEED_W-1:0] speed_o
);

  // Sum of the weights and the widths that follow from it.
  localparam int WSUM  = TAPS * (TAPS + 1) / 2;
  localparam int MW    = PULSE_W + $clog2(WSUM);
  localparam int SW    = MW + 1;
  // Reciprocal of the divisor, exact for every magnitude below 2**MW.
  localparam int K     = MW + 8;
  localparam int RW    = K - 6;
  localparam logic [63:0] RECIP = ((64'd1 << K) + 64'(SPEED_DIVISOR - 1)) / 64'(SPEED_DIVISOR);
  localparam int QW    = MW + RW - K;
  localparam int XW    = (QW > SPEED_W) ? QW : SPEED_W;

  logic [PERIOD_W-1:0]       period_q;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic signed [PULSE_W-1:0] tap_q [TAPS];
  logic                      pend_q, pend_d;
  logic signed [SW-1:0]      sum_q, wsum;
  logic                      sum_vld_q;
  logic signed [SPEED_W-1:0] speed_q, speed_d;
  logic                      out_vld_q;

  logic in_acc, sample, out_rdy, sum_rdy, pend_adv;

  // Flow control from the output register back to the input.
  assign out_rdy  = !out_vld_q || !out_stall_i;
  assign sum_rdy  = !sum_vld_q || out_rdy;
  assign pend_adv = pend_q && sum_rdy;
  assign in_stall_o = pend_q && !sum_rdy;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign sample   = cnt_q > CNT_W'(period_q);

  // Fresh taps wait for the sum stage until it takes them.
  assign pend_d   = (in_acc && sample) || (pend_q && !pend_adv);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  // Tick counter: restarts at one after a sampling tick.
  always_comb begin
    cnt_d = cnt_q + CNT_W'(1);
    if (sample) begin
      cnt_d = CNT_W'(1);
    end
  end

  // Tick counter and sample taps; the newest sample sits in tap zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
      for (int i = 0; i < TAPS; i++) begin
        tap_q[i] <= '0;
      end
    end else begin
      pend_q <= pend_d;
      if (in_acc) begin
        cnt_q <= cnt_d;
        if (sample) begin
          tap_q[0] <= pulse_count_i;
          for (int i = 1; i < TAPS; i++) begin
            tap_q[i] <= tap_q[i-1];
          end
        end
      end
    end
  end

  // Weighted sum: the newest tap has weight TAPS, the oldest weight one.
  always_comb begin
    wsum = '0;
    for (int i = 0; i < TAPS; i++) begin
      wsum = wsum + SW'(tap_q[i]) * SW'(TAPS - i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
    end else if (sum_rdy) begin
      sum_vld_q <= pend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_adv) begin
      sum_q <= wsum;
    end
  end

  // Divide by the constant through the reciprocal, truncating toward zero, then saturate.
  logic              neg;
  logic [MW-1:0]     mag;
  logic [MW+RW-1:0]  prod;
  logic [XW-1:0]     quo;

  always_comb begin
    neg  = sum_q[SW-1];
    mag  = neg ? MW'(-sum_q) : MW'(sum_q);
    prod = (MW+RW)'(mag) * (MW+RW)'(RECIP[RW-1:0]);
    quo  = XW'(prod[K +: QW]);
    if (!neg && quo > XW'(SPEED_MAX)) begin
      speed_d = SPEED_W'(SPEED_MAX);
    end else if (neg && quo > XW'(SPEED_MIN_MAG)) begin
      speed_d = SPEED_W'(-SPEED_MIN_MAG);
    end else if (neg) begin
      speed_d = -SPEED_W'(quo);
    end else begin
      speed_d = SPEED_W'(quo);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= sum_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_vld_q && out_rdy) begin
      speed_q <= speed_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign speed_o     = speed_q;

  // The counter never runs past one more than the largest period.
  `EWSF_ASSERT_ALWAYS(a_cnt_bound, clk_i, cnt_q <= CNT_W'(256), "tick counter out of range")
  // A sampling word always leaves a fresh set of taps for the sum stage.
  `EWSF_ASSERT_IFF(a_sample_pend, clk_i, rst_ni, (in_acc && sample) |=> pend_q,
                   "sample word lost before the sum stage")
  // A blocked sum stage holds its word.
  `EWSF_ASSERT_IFF(a_sum_hold, clk_i, rst_ni,
                   (sum_vld_q && !out_rdy) |=> (sum_vld_q && $stable(sum_q)),
                   "sum stage changed while blocked")

endmodule
